>>> rtl/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/ipc_pkg.sv
// types, constants and helper functions of the interrupt priority controller
package ipc_pkg;

	// source counts
	localparam int MASKABLE_SOURCES = 60;
	localparam int SOFTWARE_SOURCES = 64;

	// pending vector layout
	localparam int SRC_TOTAL = 128;
	localparam int SRC_W     = 7;
	localparam int IDX_W     = 6;
	localparam int SPAN_W    = 64;

	localparam logic [SRC_W-1:0] SRC_RESET     = 7'd0;
	localparam logic [SRC_W-1:0] SRC_BREAK     = 7'd1;
	localparam logic [SRC_W-1:0] SRC_EMU       = 7'd2;
	localparam logic [SRC_W-1:0] SRC_NMI       = 7'd3;
	localparam logic [SRC_W-1:0] SRC_MASK_BASE = 7'd4;
	localparam logic [SRC_W-1:0] SRC_MASK_END  = 7'(4 + MASKABLE_SOURCES);
	localparam logic [SRC_W-1:0] SRC_SOFT_BASE = 7'h40;
	localparam logic [SRC_W-1:0] SOFT_COUNT    = 7'(SOFTWARE_SOURCES);

	// windows of live bits in the low and high halves of the pending vector
	localparam logic [SPAN_W-1:0] MASK_WIN =
		((64'd1 << MASKABLE_SOURCES) - 64'd1) << 4;
	localparam logic [SPAN_W-1:0] SOFT_WIN = (SOFTWARE_SOURCES == SPAN_W) ? {SPAN_W{1'b1}} :
		((64'd1 << SOFTWARE_SOURCES) - 64'd1);

	// exception levels
	localparam logic [1:0] LVL_RESET = 2'd0;
	localparam logic [1:0] LVL_IRQ   = 2'd1;
	localparam logic [1:0] LVL_NMI   = 2'd2;
	localparam logic [1:0] LVL_EMU   = 2'd3;

	typedef enum logic [1:0] {
		MODE_RUN  = 2'd0,
		MODE_HALT = 2'd1,
		MODE_STOP = 2'd2
	} mode_t;

	typedef enum logic [3:0] {
		KIND_TICK     = 4'd0,
		KIND_BREAK    = 4'd1,
		KIND_EMU      = 4'd2,
		KIND_NMI      = 4'd3,
		KIND_MASKABLE = 4'd4,
		KIND_SOFTWARE = 4'd5,
		KIND_HALT     = 4'd6,
		KIND_STOP     = 4'd7,
		KIND_RESET    = 4'd8
	} kind_t;

	// state update request from the arbiter to the pending store
	typedef struct packed {
		logic             set_en;
		logic [SRC_W-1:0] set_idx;
		logic             clr_en;
		logic [SRC_W-1:0] clr_idx;
		logic             mode_we;
		mode_t            mode_next;
	} upd_t;

	// one result item
	typedef struct packed {
		logic             cpu_reset;
		logic             take_valid;
		logic [1:0]       take_level;
		logic [SRC_W-1:0] take_vector;
		logic             peripheral_tick;
		logic             cpu_step;
		mode_t            cpu_mode;
		logic             fault;
	} res_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] idx;
	} first_t;

	// lowest set bit of a 64-bit word: group of eight first, then bit in group
	function automatic first_t lowest64(input logic [SPAN_W-1:0] vec);
		first_t     r;
		logic [7:0] grp_any;
		logic [2:0] grp;
		logic [7:0] byte_v;
		logic [2:0] bit_i;
		for (int g = 0; g < 8; g++) begin
			grp_any[g] = |vec[g*8 +: 8];
		end
		grp = 3'd0;
		for (int g = 7; g >= 0; g--) begin
			if (grp_any[g]) grp = 3'(g);
		end
		byte_v = vec[{grp, 3'b000} +: 8];
		bit_i = 3'd0;
		for (int b = 7; b >= 0; b--) begin
			if (byte_v[b]) bit_i = 3'(b);
		end
		r.found = |grp_any;
		r.idx   = {grp, bit_i};
		return r;
	endfunction

endpackage

>>> rtl/ipc_arbiter.sv
// event decode and fixed-priority selection over the pending requests
module ipc_arbiter (
	input  logic                       active,
	input  logic [3:0]                 kind,
	input  logic [5:0]                 source_index,
	input  logic [1:0]                 cpu_level,
	input  logic                       master_enable,
	input  logic [ipc_pkg::SRC_TOTAL-1:0] pending,
	input  ipc_pkg::mode_t             mode,
	output ipc_pkg::upd_t              upd,
	output ipc_pkg::res_t              res
);
	import ipc_pkg::*;

	kind_t            k;
	first_t           soft_first;
	first_t           mask_first;
	logic             found;
	logic             raise;
	logic [SRC_W-1:0] pick;
	logic [1:0]       pick_lvl;
	logic [SRC_W-1:0] idx_ext;
	logic             above_one;
	mode_t            mode_next;

	// candidate encoders for the two wide request groups
	assign soft_first = lowest64(pending[SRC_TOTAL-1 -: SPAN_W] & SOFT_WIN);
	assign mask_first = lowest64(pending[SPAN_W-1:0] & MASK_WIN);
	assign idx_ext    = SRC_W'(source_index);
	assign above_one  = cpu_level > 2'd1;

	// fixed priority pick for a tick
	always_comb begin
		found    = 1'b1;
		raise    = 1'b1;
		pick     = SRC_RESET;
		pick_lvl = LVL_RESET;
		if (pending[SRC_RESET]) begin
			pick     = SRC_RESET;
			pick_lvl = LVL_RESET;
		end else if (soft_first.found) begin
			pick     = SRC_SOFT_BASE + SRC_W'(soft_first.idx);
			pick_lvl = LVL_IRQ;
			raise    = !above_one;
		end else if (pending[SRC_EMU]) begin
			pick     = SRC_EMU;
			pick_lvl = LVL_EMU;
		end else if (pending[SRC_BREAK]) begin
			pick     = SRC_BREAK;
			pick_lvl = LVL_NMI;
		end else if (pending[SRC_NMI] && cpu_level <= 2'd2) begin
			pick     = SRC_NMI;
			pick_lvl = LVL_NMI;
		end else if (mask_first.found && !above_one) begin
			pick     = SRC_W'(mask_first.idx);
			pick_lvl = LVL_IRQ;
			raise    = master_enable;
		end else begin
			found = 1'b0;
			raise = 1'b0;
		end
	end

	// per-kind result and state update
	always_comb begin
		k         = kind_t'(kind);
		mode_next = mode;
		res       = '0;
		upd       = '0;
		unique case (k)
			KIND_TICK: begin
				res.peripheral_tick = (mode != MODE_STOP);
				if (found) begin
					mode_next   = MODE_RUN;
					upd.clr_en  = 1'b1;
					upd.clr_idx = pick;
					res.fault   = (pick >= SRC_SOFT_BASE) && above_one;
					if (raise) begin
						res.take_valid  = 1'b1;
						res.take_level  = pick_lvl;
						res.take_vector = pick;
					end
				end
				res.cpu_step = (mode_next == MODE_RUN);
			end
			KIND_BREAK: begin
				upd.set_en = 1'b1;
				if (above_one) begin
					res.cpu_reset = 1'b1;
					upd.set_idx   = SRC_RESET;
					mode_next     = MODE_RUN;
				end else begin
					upd.set_idx = SRC_BREAK;
				end
			end
			KIND_EMU: begin
				upd.set_en  = 1'b1;
				upd.set_idx = SRC_EMU;
			end
			KIND_NMI: begin
				upd.set_en  = 1'b1;
				upd.set_idx = SRC_NMI;
			end
			KIND_MASKABLE: begin
				if (idx_ext < SRC_MASK_BASE || idx_ext >= SRC_MASK_END) begin
					res.fault = 1'b1;
				end else begin
					upd.set_en  = 1'b1;
					upd.set_idx = idx_ext;
				end
			end
			KIND_SOFTWARE: begin
				// out-of-range software numbers are ignored without a fault
				upd.set_en  = idx_ext < SOFT_COUNT;
				upd.set_idx = SRC_SOFT_BASE + idx_ext;
			end
			KIND_HALT: mode_next = MODE_HALT;
			KIND_STOP: mode_next = MODE_STOP;
			KIND_RESET: begin
				res.cpu_reset = 1'b1;
				upd.set_en    = 1'b1;
				upd.set_idx   = SRC_RESET;
				mode_next     = MODE_RUN;
			end
			default: ;
		endcase
		res.cpu_mode  = mode_next;
		upd.mode_next = mode_next;
		upd.mode_we   = active;
		upd.set_en    = upd.set_en & active;
		upd.clr_en    = upd.clr_en & active;
	end

endmodule

>>> rtl/ipc_pending.sv
// pending request bits and run mode register
module ipc_pending (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ipc_pkg::upd_t                 upd,
	output logic [ipc_pkg::SRC_TOTAL-1:0] pending,
	output ipc_pkg::mode_t                mode
);
	import ipc_pkg::*;

	logic [SRC_TOTAL-1:0] pending_q;
	mode_t                mode_q;

	// raise and clear of single request bits, mode update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= SRC_TOTAL'(1) << SRC_RESET;
			mode_q    <= MODE_RUN;
		end else begin
			if (upd.set_en) pending_q[upd.set_idx] <= 1'b1;
			if (upd.clr_en) pending_q[upd.clr_idx] <= 1'b0;
			if (upd.mode_we) mode_q <= upd.mode_next;
		end
	end

	assign pending = pending_q;
	assign mode    = mode_q;

endmodule

>>> rtl/interrupt_priority_controller_top.sv
// top level of the interrupt priority controller: input and result registers
//
// Usage:
//   The input channel (in_valid, in_stall) carries one event item per
//   cycle while in_stall is low: a tick, a raise of a break, emulator,
//   nonmaskable, maskable, software or reset request, or a halt or stop
//   command. Every accepted item yields exactly one result item on the
//   output channel (out_valid, out_stall).
//   The item is registered in the input register at acceptance, then
//   decoded, arbitrated and applied to the pending bits while its result
//   is written into the result register.
//   Throughput is one item per cycle while out_stall is low; the pending
//   bits and run mode are updated at the same edge the result is
//   registered, so the following item sees the new state with no bubble.
//   Reset leaves only the reset request pending, the run mode at run,
//   and both registers empty.
//   When the receiver stalls, the result register holds its item; one
//   more item may still enter the input register, after which in_stall
//   rises until the result is taken.
module interrupt_priority_controller_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [3:0] kind,
	input  logic [5:0] source_index,
	input  logic [1:0] cpu_level,
	input  logic       master_enable,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       cpu_reset,
	output logic       take_valid,
	output logic [1:0] take_level,
	output logic [6:0] take_vector,
	output logic       peripheral_tick,
	output logic       cpu_step,
	output logic [1:0] cpu_mode,
	output logic       fault
);
	import ipc_pkg::*;

	logic                 valid_s1;
	logic [3:0]           kind_s1;
	logic [5:0]           index_s1;
	logic [1:0]           level_s1;
	logic                 enable_s1;
	logic                 advance;
	logic                 out_valid_q;
	res_t                 res_q;
	res_t                 res;
	upd_t                 upd;
	logic [SRC_TOTAL-1:0] pending;
	mode_t                mode;

	// pipeline control
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1   <= kind;
			index_s1  <= source_index;
			level_s1  <= cpu_level;
			enable_s1 <= master_enable;
		end
	end

	ipc_arbiter u_arbiter (
		.active        (advance),
		.kind          (kind_s1),
		.source_index  (index_s1),
		.cpu_level     (level_s1),
		.master_enable (enable_s1),
		.pending       (pending),
		.mode          (mode),
		.upd           (upd),
		.res           (res)
	);

	ipc_pending u_pending (
		.clk     (clk),
		.arst_n  (arst_n),
		.upd     (upd),
		.pending (pending),
		.mode    (mode)
	);

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (advance) res_q <= res;
	end

	assign out_valid       = out_valid_q;
	assign cpu_reset       = res_q.cpu_reset;
	assign take_valid      = res_q.take_valid;
	assign take_level      = res_q.take_level;
	assign take_vector     = res_q.take_vector;
	assign peripheral_tick = res_q.peripheral_tick;
	assign cpu_step        = res_q.cpu_step;
	assign cpu_mode        = res_q.cpu_mode;
	assign fault           = res_q.fault;

endmodule

>>> rtl/ipc_checker.sv
// port-level checker of the interrupt priority controller and its bind
`include "assert_macros.svh"

module ipc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       cpu_reset,
	input logic       take_valid,
	input logic [1:0] take_level,
	input logic [6:0] take_vector,
	input logic       cpu_step,
	input logic [1:0] cpu_mode,
	input logic       fault
);
	import ipc_pkg::*;

	// an idle result carries no vector or level
	`ASSERT_IMPLIES(a_idle_take, clk, arst_n, out_valid && !take_valid, take_level == LVL_RESET && take_vector == SRC_RESET, "take fields set without a take")
	// a reset result never raises an interrupt and leaves the cpu running
	`ASSERT_IMPLIES(a_reset_run, clk, arst_n, out_valid && cpu_reset, !take_valid && cpu_mode == MODE_RUN && !cpu_step, "reset result inconsistent")
	// a taken software request is at level one, and software faults never take
	`ASSERT_IMPLIES(a_soft_level, clk, arst_n, out_valid && take_valid && take_vector >= SRC_SOFT_BASE, take_level == LVL_IRQ && !fault, "software take at wrong level")
	// the cpu only steps in run mode
	`ASSERT_IMPLIES(a_step_run, clk, arst_n, out_valid && cpu_step, cpu_mode == MODE_RUN, "cpu step outside run mode")
	// a stalled result item holds
	`ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(take_vector) && $stable(cpu_mode), "stalled result changed")

endmodule

bind interrupt_priority_controller_top ipc_checker u_ipc_checker (.*);

>>> tb/tb_interrupt_priority_controller_top.sv
// testbench of the interrupt priority controller: directed and random events checked against a predictor
module tb_interrupt_priority_controller_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ipc_pkg::*;

	localparam int          RESET_CYCLES  = 11;
	localparam int          RANDOM_ITEMS  = 1150;
	localparam int          HOLD_CYCLES   = 150;
	localparam int          DRAIN_CYCLES  = 8;
	localparam int          IDLE_PERCENT  = 38;
	localparam int          LIMIT_NS      = 400_000;
	localparam logic [3:0]  KIND_SPARE_LO = 4'd9;
	localparam logic [3:0]  KIND_SPARE_HI = 4'd15;

	logic       clk;
	logic       arst_n        = 1'b0;
	logic       in_valid      = 1'b0;
	logic       in_stall;
	logic [3:0] kind          = '0;
	logic [5:0] source_index  = '0;
	logic [1:0] cpu_level     = '0;
	logic       master_enable = 1'b0;
	logic       out_valid;
	logic       out_stall     = 1'b0;
	logic       cpu_reset;
	logic       take_valid;
	logic [1:0] take_level;
	logic [6:0] take_vector;
	logic       peripheral_tick;
	logic       cpu_step;
	logic [1:0] cpu_mode;
	logic       fault;

	// shared between the sender and the receiver
	bit steady       = 1'b0;
	bit hold_off_req = 1'b0;

	// pending requests and run mode mirrored, one awaited result per accepted event
	class interrupt_ledger;
		logic [SRC_TOTAL-1:0] pending;
		mode_t                cur_mode;
		res_t                 awaited[$];
		int                   mismatch_count;

		function new();
			pending        = '0;
			pending[SRC_RESET] = 1'b1;
			cur_mode       = MODE_RUN;
			mismatch_count = 0;
		endfunction

		function int outstanding();
			return awaited.size();
		endfunction

		// work out the result of one accepted event and update the mirrored state
		function void note_event(logic [3:0] k, logic [5:0] idx, logic [1:0] lvl, logic en);
			res_t             r;
			bit               found;
			bit               raise;
			logic [SRC_W-1:0] pick;
			r     = '0;
			found = 1'b0;
			pick  = SRC_RESET;
			case (kind_t'(k))
				KIND_TICK: begin
					r.peripheral_tick = (cur_mode != MODE_STOP);
					if (pending[SRC_RESET]) begin
						found = 1'b1;
						pick  = SRC_RESET;
					end
					for (int i = 0; i < SOFTWARE_SOURCES && !found; i++) begin
						if (pending[SRC_SOFT_BASE + i]) begin
							found = 1'b1;
							pick  = SRC_W'(SRC_SOFT_BASE + i);
						end
					end
					if (!found && pending[SRC_EMU]) begin
						found = 1'b1;
						pick  = SRC_EMU;
					end
					if (!found && pending[SRC_BREAK]) begin
						found = 1'b1;
						pick  = SRC_BREAK;
					end
					if (!found && pending[SRC_NMI] && lvl <= LVL_NMI) begin
						found = 1'b1;
						pick  = SRC_NMI;
					end
					for (int i = 0; i < MASKABLE_SOURCES && !found && lvl <= LVL_IRQ; i++) begin
						if (pending[SRC_MASK_BASE + i]) begin
							found = 1'b1;
							pick  = SRC_W'(SRC_MASK_BASE + i);
						end
					end
					if (found) begin
						raise = 1'b1;
						// software taken above level one is swallowed with a fault
						if (pick >= SRC_SOFT_BASE && lvl > LVL_IRQ) begin
							raise   = 1'b0;
							r.fault = 1'b1;
						end
						// maskable dropped while interrupts are disabled
						if (pick >= SRC_MASK_BASE && pick < SRC_SOFT_BASE && !en) raise = 1'b0;
						if (raise) begin
							r.take_valid  = 1'b1;
							r.take_vector = pick;
							if (pick == SRC_RESET) r.take_level = LVL_RESET;
							else if (pick == SRC_BREAK || pick == SRC_NMI) r.take_level = LVL_NMI;
							else if (pick == SRC_EMU) r.take_level = LVL_EMU;
							else r.take_level = LVL_IRQ;
						end
						pending[pick] = 1'b0;
						cur_mode      = MODE_RUN;
					end
					r.cpu_step = (cur_mode == MODE_RUN);
				end
				KIND_BREAK: begin
					// break above level one behaves as a reset event
					if (lvl > LVL_IRQ) begin
						r.cpu_reset        = 1'b1;
						pending[SRC_RESET] = 1'b1;
						cur_mode           = MODE_RUN;
					end else begin
						pending[SRC_BREAK] = 1'b1;
					end
				end
				KIND_EMU: pending[SRC_EMU] = 1'b1;
				KIND_NMI: pending[SRC_NMI] = 1'b1;
				KIND_MASKABLE: begin
					if ({1'b0, idx} < SRC_MASK_BASE || {1'b0, idx} >= SRC_MASK_END) r.fault = 1'b1;
					else pending[idx] = 1'b1;
				end
				KIND_SOFTWARE: begin
					if ({1'b0, idx} < SOFT_COUNT) pending[SRC_SOFT_BASE + idx] = 1'b1;
				end
				KIND_HALT: cur_mode = MODE_HALT;
				KIND_STOP: cur_mode = MODE_STOP;
				KIND_RESET: begin
					r.cpu_reset        = 1'b1;
					pending[SRC_RESET] = 1'b1;
					cur_mode           = MODE_RUN;
				end
				default: begin
				end
			endcase
			r.cpu_mode = cur_mode;
			awaited.push_back(r);
		endfunction

		task report(string msg);
			mismatch_count++;
			$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		task compare_field(string name, logic [6:0] got, logic [6:0] want);
			if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
		endtask

		// compare one result item with the oldest awaited one
		task check_result(res_t got);
			res_t want;
			if (awaited.size() == 0) begin
				report("result item with nothing awaited");
				return;
			end
			want = awaited.pop_front();
			compare_field("cpu_reset", 7'(got.cpu_reset), 7'(want.cpu_reset));
			compare_field("take_valid", 7'(got.take_valid), 7'(want.take_valid));
			compare_field("take_level", 7'(got.take_level), 7'(want.take_level));
			compare_field("take_vector", 7'(got.take_vector), 7'(want.take_vector));
			compare_field("peripheral_tick", 7'(got.peripheral_tick), 7'(want.peripheral_tick));
			compare_field("cpu_step", 7'(got.cpu_step), 7'(want.cpu_step));
			compare_field("cpu_mode", 7'(got.cpu_mode), 7'(want.cpu_mode));
			compare_field("fault", 7'(got.fault), 7'(want.fault));
		endtask
	endclass

	interrupt_ledger ledger = new();

	interrupt_priority_controller_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.kind            (kind),
		.source_index    (source_index),
		.cpu_level       (cpu_level),
		.master_enable   (master_enable),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.cpu_reset       (cpu_reset),
		.take_valid      (take_valid),
		.take_level      (take_level),
		.take_vector     (take_vector),
		.peripheral_tick (peripheral_tick),
		.cpu_step        (cpu_step),
		.cpu_mode        (cpu_mode),
		.fault           (fault)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		#(LIMIT_NS);
		$display("interrupt_priority_controller_top test failed");
		$finish;
	end

	// accepted events feed the predictor
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			ledger.note_event(kind, source_index, cpu_level, master_enable);
	end

	// accepted results are checked
	always @(posedge clk) begin
		res_t got;
		if (arst_n && out_valid && !out_stall) begin
			got = {cpu_reset, take_valid, take_level, take_vector, peripheral_tick,
				cpu_step, cpu_mode, fault};
			ledger.check_result(got);
		end
	end

	// receiver: random stalls, one long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_off_req) begin
				repeat (HOLD_CYCLES) begin
					out_stall <= 1'b1;
					@(posedge clk);
				end
				hold_off_req = 1'b0;
			end
			out_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
			@(posedge clk);
		end
	end

	// offer one event item and wait until it is taken
	task automatic send_item(input logic [3:0] k, input logic [5:0] idx,
		input logic [1:0] lvl, input logic en);
		if (!steady) begin
			while ($urandom_range(99) < IDLE_PERCENT) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid      <= 1'b1;
		kind          <= k;
		source_index  <= idx;
		cpu_level     <= lvl;
		master_enable <= en;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// mostly raises and ticks, with some mode changes, resets and spare kinds
	task automatic send_random();
		int         sel;
		logic [3:0] k;
		logic [5:0] idx;
		sel = $urandom_range(99);
		idx = 6'($urandom_range(63));
		if (sel < 40) k = KIND_TICK;
		else if (sel < 49) begin
			k = KIND_MASKABLE;
			if ($urandom_range(9) != 0) idx = 6'($urandom_range(63, SRC_MASK_BASE));
		end
		else if (sel < 57) k = KIND_SOFTWARE;
		else if (sel < 62) k = KIND_BREAK;
		else if (sel < 67) k = KIND_EMU;
		else if (sel < 72) k = KIND_NMI;
		else if (sel < 77) k = KIND_HALT;
		else if (sel < 82) k = KIND_STOP;
		else if (sel < 85) k = KIND_RESET;
		else if (sel < 88) k = 4'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO));
		else k = KIND_TICK;
		send_item(k, idx, 2'($urandom_range(3)), ($urandom_range(3) != 0));
	endtask

	// stimulus
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every kind, extremes of the fields and the corner cases
		send_item(KIND_TICK, 6'd0, 2'd0, 1'b1);      // reset request out of reset
		send_item(KIND_TICK, 6'd63, 2'd3, 1'b0);     // nothing eligible
		send_item(KIND_BREAK, 6'd0, 2'd0, 1'b1);
		send_item(KIND_BREAK, 6'd0, 2'd3, 1'b1);     // break above level one resets
		send_item(KIND_EMU, 6'd0, 2'd0, 1'b1);
		send_item(KIND_NMI, 6'd0, 2'd0, 1'b1);
		send_item(KIND_MASKABLE, 6'd4, 2'd0, 1'b1);
		send_item(KIND_MASKABLE, 6'd63, 2'd0, 1'b1);
		send_item(KIND_MASKABLE, 6'd0, 2'd0, 1'b1);  // invalid maskable number
		send_item(KIND_MASKABLE, 6'd3, 2'd0, 1'b1);
		send_item(KIND_SOFTWARE, 6'd0, 2'd0, 1'b1);
		send_item(KIND_SOFTWARE, 6'd63, 2'd0, 1'b1);
		send_item(KIND_SOFTWARE, 6'd63, 2'd0, 1'b1); // already pending
		send_item(KIND_HALT, 6'd0, 2'd0, 1'b1);
		send_item(KIND_TICK, 6'd0, 2'd3, 1'b1);      // reset wins over the rest
		send_item(KIND_TICK, 6'd0, 2'd3, 1'b1);      // software above level one faults
		send_item(KIND_STOP, 6'd0, 2'd0, 1'b1);
		send_item(KIND_TICK, 6'd0, 2'd1, 1'b1);
		send_item(KIND_TICK, 6'd0, 2'd3, 1'b1);      // emulator
		send_item(KIND_TICK, 6'd0, 2'd3, 1'b1);      // break
		send_item(KIND_TICK, 6'd0, 2'd3, 1'b1);      // nonmaskable held off at level 3
		send_item(KIND_TICK, 6'd0, 2'd2, 1'b1);      // nonmaskable
		send_item(KIND_TICK, 6'd0, 2'd1, 1'b0);      // maskable dropped while disabled
		send_item(KIND_TICK, 6'd0, 2'd0, 1'b1);
		send_item(KIND_STOP, 6'd0, 2'd0, 1'b1);
		send_item(KIND_TICK, 6'd0, 2'd0, 1'b1);      // stopped, nothing pending
		send_item(KIND_SPARE_LO, 6'd63, 2'd3, 1'b1);
		send_item(KIND_SPARE_HI, 6'd0, 2'd0, 1'b0);
		send_item(KIND_RESET, 6'd0, 2'd0, 1'b1);

		// random events, with a long receiver hold-off and a stretch with no idling
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 300) hold_off_req = 1'b1;
			if (n == 600) steady = 1'b1;
			if (n == 800) steady = 1'b0;
			send_random();
		end
		in_valid <= 1'b0;

		// drain the awaited results, then allow for stray items
		while (ledger.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (ledger.mismatch_count == 0) begin
			$display("interrupt_priority_controller_top test passed");
		end else begin
			$display("interrupt_priority_controller_top test failed");
		end
		$finish;
	end

endmodule
